// ===== hdl/wcm_pkg.sv =====
// Package: widths, kinds, state codes and the queue entry for weighted_cluster_moments.
`timescale 1ns / 1ps
`default_nettype none
package wcm_pkg;

    // Capacity default and the largest capacity that the sum widths cover.
    localparam int MAX_HITS_DEF = 128;
    localparam int CNT_W        = 11;
    localparam int SUMW_W       = 16 + CNT_W;     // weight sum
    localparam int M1_W         = 34 + CNT_W;     // signed first moment
    localparam int M2_W         = 48 + CNT_W;     // unsigned second moment
    localparam int MXY_W        = M2_W + 1;       // signed cross moment
    localparam int DIVN_W       = M2_W + 8;       // dividend, 8 fraction bits added
    localparam int QDEPTH       = 2;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_SEED,
        KIND_HIT,
        KIND_HOLD
    } kind_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_PROD,
        F_ACC,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_MUL,
        B_FIN
    } back_state_t;

    typedef struct packed {
        kind_t                    kind;
        logic                     seeded;
        logic signed [15:0]       seed_x;
        logic signed [15:0]       seed_y;
        logic [SUMW_W-1:0]        sum_w;
        logic signed [M1_W-1:0]   sum_dx;
        logic signed [M1_W-1:0]   sum_dy;
        logic [M2_W-1:0]          sum_dxx;
        logic [M2_W-1:0]          sum_dyy;
        logic signed [MXY_W-1:0]  sum_dxy;
    } q_entry_t;

endpackage
`default_nettype wire

// ===== hdl/wcm_ifs.sv =====
// Interfaces: hit request channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface wcm_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        signal;

    modport source (output valid, op, pos_x, pos_y, signal, input ready);
    modport sink   (input valid, op, pos_x, pos_y, signal, output ready);
endinterface

interface wcm_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic [39:0]        var_x;
    logic [39:0]        var_y;
    logic signed [39:0] cov_xy;
    logic [7:0]         hit_count;
    logic [6:0]         x_spread_hits;
    logic [6:0]         y_spread_hits;
    logic               valid_res;

    modport source (output valid, mean_x, mean_y, var_x, var_y, cov_xy, hit_count,
                    x_spread_hits, y_spread_hits, valid_res, input ready);
    modport sink   (input valid, mean_x, mean_y, var_x, var_y, cov_xy, hit_count,
                    x_spread_hits, y_spread_hits, valid_res, output ready);
endinterface
`default_nettype wire

// ===== hdl/wcm_front.sv =====
// Front end: accept hit requests, update seed and moment sums, queue a snapshot.
`timescale 1ns / 1ps
`default_nettype none
module wcm_front #(
    parameter int MAX_HITS = wcm_pkg::MAX_HITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    wcm_in_if.sink          hit_in,
    output wcm_pkg::q_entry_t entry,
    output logic            push,
    input  wire logic       full
);
    import wcm_pkg::*;

    localparam int PAD1  = M1_W - 34;
    localparam int PAD2  = M2_W - 49;
    localparam int PADXY = MXY_W - 51;

    front_state_t state_reg, state_next;

    logic                    op_reg;
    logic signed [15:0]      x_reg, y_reg;
    logic [15:0]             w_reg;
    logic signed [33:0]      p_dxw_reg, p_dyw_reg, p_dxx_reg, p_dyy_reg, p_dxy_reg;
    logic signed [33:0]      p_dxw_next, p_dyw_next, p_dxx_next, p_dyy_next, p_dxy_next;

    kind_t                   kind_reg, kind_next;
    logic                    seeded_reg, seeded_next;
    logic signed [15:0]      seed_x_reg, seed_x_next, seed_y_reg, seed_y_next;
    logic [SUMW_W-1:0]       sum_w_reg, sum_w_next;
    logic signed [M1_W-1:0]  sum_dx_reg, sum_dx_next, sum_dy_reg, sum_dy_next;
    logic [M2_W-1:0]         sum_dxx_reg, sum_dxx_next, sum_dyy_reg, sum_dyy_next;
    logic signed [MXY_W-1:0] sum_dxy_reg, sum_dxy_next;
    logic [CNT_W-1:0]        n_reg, n_next;

    logic signed [16:0]      dx, dy, w_s;
    logic [48:0]             dxx_w, dyy_w;
    logic signed [50:0]      dxy_w;

    logic accept;

    assign accept = hit_in.valid && hit_in.ready;
    assign dx     = {x_reg[15], x_reg} - {seed_x_reg[15], seed_x_reg};
    assign dy     = {y_reg[15], y_reg} - {seed_y_reg[15], seed_y_reg};
    assign w_s    = $signed({1'b0, w_reg});
    assign dxx_w  = p_dxx_reg[32:0] * w_reg;
    assign dyy_w  = p_dyy_reg[32:0] * w_reg;
    assign dxy_w  = p_dxy_reg * w_s;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (accept) state_next = F_PROD;
            F_PROD:
            begin
                if (op_reg == OP_ADD && seeded_reg && n_reg < CNT_W'(MAX_HITS))
                    state_next = F_ACC;
                else
                    state_next = F_PUSH;
            end
            F_ACC:  state_next = F_PUSH;
            F_PUSH: if (!full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        hit_in.ready = (state_reg == F_IDLE);
        push         = (state_reg == F_PUSH) && !full;
    end

    // Sums
    always_comb
    begin
        kind_next    = kind_reg;
        seeded_next  = seeded_reg;
        seed_x_next  = seed_x_reg;
        seed_y_next  = seed_y_reg;
        sum_w_next   = sum_w_reg;
        sum_dx_next  = sum_dx_reg;
        sum_dy_next  = sum_dy_reg;
        sum_dxx_next = sum_dxx_reg;
        sum_dyy_next = sum_dyy_reg;
        sum_dxy_next = sum_dxy_reg;
        n_next       = n_reg;
        p_dxw_next   = dx * w_s;
        p_dyw_next   = dy * w_s;
        p_dxx_next   = dx * dx;
        p_dyy_next   = dy * dy;
        p_dxy_next   = dx * dy;
        if (state_reg == F_PROD)
        begin
            if (op_reg == OP_CLEAR)
            begin
                kind_next    = KIND_CLEAR;
                seeded_next  = 1'b0;
                seed_x_next  = '0;
                seed_y_next  = '0;
                sum_w_next   = '0;
                sum_dx_next  = '0;
                sum_dy_next  = '0;
                sum_dxx_next = '0;
                sum_dyy_next = '0;
                sum_dxy_next = '0;
                n_next       = '0;
            end
            else if (!seeded_reg)
            begin
                kind_next   = KIND_SEED;
                seeded_next = 1'b1;
                seed_x_next = x_reg;
                seed_y_next = y_reg;
                sum_w_next  = sum_w_reg + SUMW_W'(w_reg);
                n_next      = CNT_W'(1);
            end
            else if (n_reg < CNT_W'(MAX_HITS))
                kind_next = KIND_HIT;
            else
                kind_next = KIND_HOLD;
        end
        else if (state_reg == F_ACC)
        begin
            sum_w_next   = sum_w_reg + SUMW_W'(w_reg);
            sum_dx_next  = sum_dx_reg + {{PAD1{p_dxw_reg[33]}}, p_dxw_reg};
            sum_dy_next  = sum_dy_reg + {{PAD1{p_dyw_reg[33]}}, p_dyw_reg};
            sum_dxx_next = sum_dxx_reg + {{PAD2{1'b0}}, dxx_w};
            sum_dyy_next = sum_dyy_reg + {{PAD2{1'b0}}, dyy_w};
            sum_dxy_next = sum_dxy_reg + {{PADXY{dxy_w[50]}}, dxy_w};
            n_next       = n_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            kind_reg    <= KIND_CLEAR;
            seeded_reg  <= 1'b0;
            seed_x_reg  <= '0;
            seed_y_reg  <= '0;
            sum_w_reg   <= '0;
            sum_dx_reg  <= '0;
            sum_dy_reg  <= '0;
            sum_dxx_reg <= '0;
            sum_dyy_reg <= '0;
            sum_dxy_reg <= '0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            kind_reg    <= kind_next;
            seeded_reg  <= seeded_next;
            seed_x_reg  <= seed_x_next;
            seed_y_reg  <= seed_y_next;
            sum_w_reg   <= sum_w_next;
            sum_dx_reg  <= sum_dx_next;
            sum_dy_reg  <= sum_dy_next;
            sum_dxx_reg <= sum_dxx_next;
            sum_dyy_reg <= sum_dyy_next;
            sum_dxy_reg <= sum_dxy_next;
            n_reg       <= n_next;
        end
    end

    // Request latch and product stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= hit_in.op;
            x_reg  <= hit_in.pos_x;
            y_reg  <= hit_in.pos_y;
            w_reg  <= hit_in.signal;
        end
        if (state_reg == F_PROD)
        begin
            p_dxw_reg <= p_dxw_next;
            p_dyw_reg <= p_dyw_next;
            p_dxx_reg <= p_dxx_next;
            p_dyy_reg <= p_dyy_next;
            p_dxy_reg <= p_dxy_next;
        end
    end

    always_comb
    begin
        entry.kind    = kind_reg;
        entry.seeded  = seeded_reg;
        entry.seed_x  = seed_x_reg;
        entry.seed_y  = seed_y_reg;
        entry.sum_w   = sum_w_reg;
        entry.sum_dx  = sum_dx_reg;
        entry.sum_dy  = sum_dy_reg;
        entry.sum_dxx = sum_dxx_reg;
        entry.sum_dyy = sum_dyy_reg;
        entry.sum_dxy = sum_dxy_reg;
    end
endmodule
`default_nettype wire

// ===== hdl/wcm_queue.sv =====
// Two-entry queue of moment snapshots between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module wcm_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wcm_pkg::q_entry_t wr_data,
    output logic                   full,
    input  wire logic              pop,
    output wcm_pkg::q_entry_t      rd_data,
    output logic                   empty
);
    import wcm_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    q_entry_t          mem_reg [QDEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full    = (count_reg == CW'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/wcm_div.sv =====
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wcm_div #(
    parameter int NW = 8,
    parameter int DW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [NW-1:0]      quo
);
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, quo_reg;
    logic [DW-1:0] den_reg, rem_reg;
    logic [KW-1:0] cnt_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign busy  = (cnt_reg != '0);
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= KW'(NW);
        else if (busy)
            cnt_reg <= cnt_reg - KW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/wcm_back.sv =====
// Back end: divide moments by the weight sum, classify spread, drive results.
`timescale 1ns / 1ps
`default_nettype none
module wcm_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              empty,
    input  wire wcm_pkg::q_entry_t rd_data,
    output logic                   pop,
    wcm_out_if.source              res_out
);
    import wcm_pkg::*;

    localparam int PAD1 = DIVN_W - M1_W - 8;

    back_state_t state_reg, state_next;
    q_entry_t    e_reg;
    logic        live_reg;

    logic [M1_W-1:0]   mag_dx, mag_dy;
    logic [MXY_W-1:0]  mag_dxy;
    logic [DIVN_W-1:0] q_dx, q_dy, q_dxx, q_dyy, q_dxy;
    logic [4:0]        busy_v;
    logic              start, live, load, e_live;
    logic [47:0]       sq_x, sq_y, sq_xy;

    logic signed [25:0] mdx_reg, mdy_reg, last_mean_reg;
    logic [39:0]        axx_reg, ayy_reg, pxx_reg, pyy_reg, pxy_reg;
    logic signed [41:0] axy_reg;
    logic               pneg_reg;
    logic [CNT_W-1:0]   cx_reg, cy_reg, cx_next, cy_next, n_next;

    logic signed [41:0] vx, vy;
    logic signed [42:0] cv, p_s;
    logic signed [25:0] mean_x_w, mean_y_w;
    logic               out_valid_reg;

    assign mag_dx  = e_reg.sum_dx[M1_W-1] ? M1_W'(-e_reg.sum_dx) : M1_W'(e_reg.sum_dx);
    assign mag_dy  = e_reg.sum_dy[M1_W-1] ? M1_W'(-e_reg.sum_dy) : M1_W'(e_reg.sum_dy);
    assign mag_dxy = e_reg.sum_dxy[MXY_W-1] ? MXY_W'(-e_reg.sum_dxy)
                                            : MXY_W'(e_reg.sum_dxy);

    assign live   = (rd_data.kind != KIND_CLEAR) && rd_data.seeded && (rd_data.sum_w != '0);
    assign e_live = (e_reg.kind != KIND_CLEAR) && e_reg.seeded && (e_reg.sum_w != '0);
    assign pop    = (state_reg == B_IDLE) && !empty;
    assign start  = (state_reg == B_DIV) && !live_reg;
    assign load   = (state_reg == B_FIN) && (!out_valid_reg || res_out.ready);

    assign sq_x  = q_dx[23:0] * q_dx[23:0];
    assign sq_y  = q_dy[23:0] * q_dy[23:0];
    assign sq_xy = q_dx[23:0] * q_dy[23:0];

    // start pulses once: live_reg is set on start and cleared on pop
    wcm_div #(.NW(DIVN_W), .DW(SUMW_W)) u_div_dx (
        .clk(clk), .rst_n(rst_n), .start(start),
        .num({{PAD1{1'b0}}, mag_dx, 8'd0}), .den(e_reg.sum_w),
        .busy(busy_v[0]), .quo(q_dx));
    wcm_div #(.NW(DIVN_W), .DW(SUMW_W)) u_div_dy (
        .clk(clk), .rst_n(rst_n), .start(start),
        .num({{PAD1{1'b0}}, mag_dy, 8'd0}), .den(e_reg.sum_w),
        .busy(busy_v[1]), .quo(q_dy));
    wcm_div #(.NW(DIVN_W), .DW(SUMW_W)) u_div_dxx (
        .clk(clk), .rst_n(rst_n), .start(start),
        .num({e_reg.sum_dxx, 8'd0}), .den(e_reg.sum_w),
        .busy(busy_v[2]), .quo(q_dxx));
    wcm_div #(.NW(DIVN_W), .DW(SUMW_W)) u_div_dyy (
        .clk(clk), .rst_n(rst_n), .start(start),
        .num({e_reg.sum_dyy, 8'd0}), .den(e_reg.sum_w),
        .busy(busy_v[3]), .quo(q_dyy));
    wcm_div #(.NW(DIVN_W), .DW(SUMW_W)) u_div_dxy (
        .clk(clk), .rst_n(rst_n), .start(start),
        .num({mag_dxy[M2_W-1:0], 8'd0}), .den(e_reg.sum_w),
        .busy(busy_v[4]), .quo(q_dxy));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!empty) state_next = live ? B_DIV : B_FIN;
            B_DIV:  if (live_reg && busy_v == '0) state_next = B_MUL;
            B_MUL:  state_next = B_FIN;
            B_FIN:  if (load) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // Spread counts: a zero weight sum counts as a zero centroid
    always_comb
    begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        case (e_reg.kind)
            KIND_CLEAR:
            begin
                cx_next = '0;
                cy_next = '0;
            end
            KIND_HIT:
            begin
                if (mean_x_w == last_mean_reg)
                    cy_next = cy_reg + CNT_W'(1);
                else
                    cx_next = cx_reg + CNT_W'(1);
            end
            default: ;
        endcase
        n_next = e_reg.seeded ? CNT_W'(1) + cx_next + cy_next : '0;
    end

    // Result arithmetic
    always_comb
    begin
        vx       = $signed({2'b0, axx_reg}) - $signed({2'b0, pxx_reg});
        vy       = $signed({2'b0, ayy_reg}) - $signed({2'b0, pyy_reg});
        p_s      = pneg_reg ? -$signed({3'b0, pxy_reg}) : $signed({3'b0, pxy_reg});
        cv       = {axy_reg[41], axy_reg} - p_s;
        mean_x_w = e_live ? mdx_reg + {{2{e_reg.seed_x[15]}}, e_reg.seed_x, 8'd0} : '0;
        mean_y_w = e_live ? mdy_reg + {{2{e_reg.seed_y[15]}}, e_reg.seed_y, 8'd0} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            live_reg      <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            last_mean_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                live_reg <= 1'b0;
            else if (start)
                live_reg <= 1'b1;
            if (load)
            begin
                cx_reg        <= cx_next;
                cy_reg        <= cy_next;
                last_mean_reg <= mean_x_w;
                out_valid_reg <= 1'b1;
            end
            else if (res_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_reg   <= rd_data;
            mdx_reg <= '0;
            mdy_reg <= '0;
            axx_reg <= '0;
            ayy_reg <= '0;
            axy_reg <= '0;
            pxx_reg <= '0;
            pyy_reg <= '0;
            pxy_reg <= '0;
            pneg_reg <= 1'b0;
        end
        else if (state_reg == B_MUL)
        begin
            mdx_reg  <= e_reg.sum_dx[M1_W-1] ? -$signed({2'b0, q_dx[23:0]})
                                              : $signed({2'b0, q_dx[23:0]});
            mdy_reg  <= e_reg.sum_dy[M1_W-1] ? -$signed({2'b0, q_dy[23:0]})
                                              : $signed({2'b0, q_dy[23:0]});
            axx_reg  <= q_dxx[39:0];
            ayy_reg  <= q_dyy[39:0];
            axy_reg  <= e_reg.sum_dxy[MXY_W-1] ? -$signed({2'b0, q_dxy[39:0]})
                                                : $signed({2'b0, q_dxy[39:0]});
            pxx_reg  <= sq_x[47:8];
            pyy_reg  <= sq_y[47:8];
            pxy_reg  <= sq_xy[47:8];
            pneg_reg <= e_reg.sum_dx[M1_W-1] != e_reg.sum_dy[M1_W-1];
        end
        if (load)
        begin
            res_out.mean_x        <= mean_x_w[23:0];
            res_out.mean_y        <= mean_y_w[23:0];
            res_out.var_x         <= vx[41] ? '0 : (vx[40] ? '1 : vx[39:0]);
            res_out.var_y         <= vy[41] ? '0 : (vy[40] ? '1 : vy[39:0]);
            if (cv > 43'sh7F_FFFF_FFFF)
                res_out.cov_xy <= 40'sh7F_FFFF_FFFF;
            else if (cv < -43'sh80_0000_0000)
                res_out.cov_xy <= 40'sh80_0000_0000;
            else
                res_out.cov_xy <= cv[39:0];
            res_out.hit_count     <= n_next[7:0];
            res_out.x_spread_hits <= cx_next[6:0];
            res_out.y_spread_hits <= cy_next[6:0];
            res_out.valid_res     <= e_live;
        end
    end

    assign res_out.valid = out_valid_reg;
endmodule
`default_nettype wire

// ===== hdl/weighted_cluster_moments.sv =====
// Top level: weighted centroid, variance and covariance of a hit cluster.
//
//  channel   dir  modport  payload
//  hit_in    in   sink     op, pos_x, pos_y, signal
//  res_out   out  source   mean_x, mean_y, var_x, var_y, cov_xy, hit_count,
//                          x_spread_hits, y_spread_hits, valid_res
//
// Every request gives exactly one result. The front takes no new request until it
// has pushed the snapshot of the last one; the back takes no new snapshot until it
// has loaded the last result. For a seeded cluster with nonzero weight the back runs
// the five bit-serial dividers; otherwise it goes straight to the result state.
// Reset (rst_n low, asynchronous) empties the cluster and the queue.
// A stalled result holds in the output register; the two-entry queue lets the
// front keep accepting requests meanwhile, until the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module weighted_cluster_moments #(
    parameter int MAX_HITS = wcm_pkg::MAX_HITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wcm_in_if.sink    hit_in,
    wcm_out_if.source res_out
);
    import wcm_pkg::*;

    q_entry_t wr_entry, rd_entry;
    logic     push, pop, full, empty;

    // Front: seed, accumulate, capacity check
    wcm_front #(.MAX_HITS(MAX_HITS)) u_front (
        .clk(clk), .rst_n(rst_n), .hit_in(hit_in),
        .entry(wr_entry), .push(push), .full(full));

    // Snapshot queue decouples accumulation from division
    wcm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .wr_data(wr_entry), .full(full),
        .pop(pop), .rd_data(rd_entry), .empty(empty));

    // Back: division, spread classification, result register
    wcm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .empty(empty), .rd_data(rd_entry), .pop(pop), .res_out(res_out));
endmodule
`default_nettype wire

// ===== hdl/wcm_checker.sv =====
// Port checker for weighted_cluster_moments and its bind.
`timescale 1ns / 1ps
`default_nettype none
module wcm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [39:0] var_x,
    input wire logic [23:0] mean_x,
    input wire logic [7:0]  hit_count,
    input wire logic [6:0]  x_spread_hits,
    input wire logic [6:0]  y_spread_hits,
    input wire logic        valid_res
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(var_x) && $stable(hit_count))
        else $error("stalled result changed");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_count != 8'd0 |->
            hit_count == 8'd1 + {1'b0, x_spread_hits} + {1'b0, y_spread_hits})
        else $error("hit count does not match spread counts");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> var_x == 40'd0 && mean_x == 24'd0)
        else $error("invalid result carries moments");
endmodule

bind weighted_cluster_moments wcm_checker u_wcm_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .var_x(res_out.var_x), .mean_x(res_out.mean_x),
    .hit_count(res_out.hit_count),
    .x_spread_hits(res_out.x_spread_hits), .y_spread_hits(res_out.y_spread_hits),
    .valid_res(res_out.valid_res));
`default_nettype wire
